/* src/rgbe_pkg.sv */
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types and constants for the RGBE 8-8-8-8 color codec.
// ----------------------------------------------------------------------------
package rgbe_pkg;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef logic [31:0]        float_type;
   typedef logic [7:0]         byte_type;
   typedef logic signed [7:0]  exp_type;

   localparam logic [7:0]  FIELD_INF    = 8'hFF;
   localparam logic [7:0]  BYTE_MAX     = 8'd255;
   localparam exp_type     EXP_MIN      = -8'sd128;
   localparam exp_type     EXP_MAX      = 8'sd127;
   // 1.0f/255.0f = 0x3B808081
   localparam logic [23:0] INV_MANT     = 24'h808081;
   localparam logic [31:0] FLOAT_INF    = 32'h7F800000;

endpackage

/* src/rgbe_encoder.sv */
// ----------------------------------------------------------------------------
// rgbe_encoder
// Float channels to three mantissa bytes and a shared exponent.
// ----------------------------------------------------------------------------
module rgbe_encoder (
   input  rgbe_pkg::float_type red_value,
   input  rgbe_pkg::float_type green_value,
   input  rgbe_pkg::float_type blue_value,
   output rgbe_pkg::byte_type  red_byte,
   output rgbe_pkg::byte_type  green_byte,
   output rgbe_pkg::byte_type  blue_byte,
   output rgbe_pkg::exp_type   shared_exponent
);
   import rgbe_pkg::*;

   function automatic logic is_pos(float_type b);
      return !b[31] && (b[30:23] != 8'd0) && !(b[30:23] == FIELD_INF && b[22:0] != 23'd0);
   endfunction

   function automatic byte_type enc_chan(float_type b, logic signed [9:0] e);
      logic signed [9:0] nf;
      logic [31:0]       p;
      logic [24:0]       m25;
      logic [32:0]       rp;
      logic [9:0]        sh;
      logic [32:0]       v;
      byte_type          r;
      nf  = $signed({2'b00, b[30:23]}) - e;
      p   = {1'b1, b[22:0]} * BYTE_MAX;
      if (p[31]) begin
         m25 = {1'b0, p[31:8]} + 25'(p[7] & ((|p[6:0]) | p[8]));
         rp  = {m25, 8'd0};
      end else begin
         m25 = {1'b0, p[30:7]} + 25'(p[6] & ((|p[5:0]) | p[7]));
         rp  = {1'b0, m25, 7'd0};
      end
      sh = 10'(10'sd150 - nf);
      v  = (sh >= 10'd33) ? 33'd0 : (rp >> sh);
      if (!is_pos(b)) begin
         r = 8'd0;
      end else if (b[30:23] == FIELD_INF) begin
         r = BYTE_MAX;
      end else if (nf <= 10'sd0) begin
         r = 8'd0;
      end else if (v > 33'd255) begin
         r = BYTE_MAX;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   float_type         mx;
   logic              any_pos;
   logic signed [9:0] e;

   always_comb begin
      mx = 32'd0;
      if (is_pos(red_value)   && red_value   > mx) mx = red_value;
      if (is_pos(green_value) && green_value > mx) mx = green_value;
      if (is_pos(blue_value)  && blue_value  > mx) mx = blue_value;
      any_pos = is_pos(red_value) || is_pos(green_value) || is_pos(blue_value);
      if (!any_pos) begin
         e = 10'(EXP_MIN);
      end else if (mx[30:23] >= 8'd254) begin
         e = 10'(EXP_MAX);
      end else begin
         e = $signed({2'b00, mx[30:23]}) - 10'sd126;
      end
   end

   assign red_byte        = enc_chan(red_value, e);
   assign green_byte      = enc_chan(green_value, e);
   assign blue_byte       = enc_chan(blue_value, e);
   assign shared_exponent = e[7:0];

endmodule

/* src/rgbe_decoder.sv */
// ----------------------------------------------------------------------------
// rgbe_decoder
// Mantissa bytes and shared exponent to single-precision channels.
// ----------------------------------------------------------------------------
module rgbe_decoder (
   input  rgbe_pkg::byte_type  red_code,
   input  rgbe_pkg::byte_type  green_code,
   input  rgbe_pkg::byte_type  blue_code,
   input  rgbe_pkg::exp_type   exponent_code,
   output rgbe_pkg::float_type red_linear,
   output rgbe_pkg::float_type green_linear,
   output rgbe_pkg::float_type blue_linear
);
   import rgbe_pkg::*;

   function automatic float_type dec_chan(byte_type c, exp_type e);
      logic [2:0]        pos;
      logic [7:0]        cn;
      logic signed [9:0] nf;
      logic signed [9:0] f;
      logic [31:0]       q;
      logic [24:0]       m25;
      float_type         r;
      pos = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (c[i]) pos = 3'(i);
      end
      cn  = c << (3'd7 - pos);
      nf  = 10'sd127 + $signed({7'd0, pos}) + 10'(e);
      q   = cn * INV_MANT;
      if (q[31]) begin
         m25 = {1'b0, q[31:8]} + 25'(q[7] & ((|q[6:0]) | q[8]));
      end else begin
         m25 = {1'b0, q[30:7]} + 25'(q[6] & ((|q[5:0]) | q[7]));
      end
      f = nf - 10'sd8 + $signed({9'd0, q[31]}) + $signed({9'd0, m25[24]});
      if (c == 8'd0 || nf <= 10'sd0 || f <= 10'sd0) begin
         r = 32'd0;
      end else if (nf >= 10'sd255) begin
         r = FLOAT_INF;
      end else begin
         r = {1'b0, f[7:0], (m25[24] ? 23'd0 : m25[22:0])};
      end
      return r;
   endfunction

   assign red_linear   = dec_chan(red_code, exponent_code);
   assign green_linear = dec_chan(green_code, exponent_code);
   assign blue_linear  = dec_chan(blue_code, exponent_code);

endmodule

/* src/rgbe8888_color_codec.sv */
// ----------------------------------------------------------------------------
// rgbe8888_color_codec
// RGBE 8-8-8-8 shared-exponent color encoder/decoder, one color per cycle.
// ----------------------------------------------------------------------------
// A transaction is taken on any clock with start high; busy is always low, so
// one color may be issued every cycle. The result passes one input register,
// one pass of encode/decode logic and one result register, then shows on the
// rsp_ ports for exactly one cycle, marked by rsp_valid. The receiver cannot
// stall. Unused result fields of the other operation are zero.
module rgbe8888_color_codec (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  rgbe_pkg::float_type req_red_value,
   input  rgbe_pkg::float_type req_green_value,
   input  rgbe_pkg::float_type req_blue_value,
   input  rgbe_pkg::byte_type  req_red_code,
   input  rgbe_pkg::byte_type  req_green_code,
   input  rgbe_pkg::byte_type  req_blue_code,
   input  rgbe_pkg::exp_type   req_exponent_code,
   output logic                rsp_valid,
   output rgbe_pkg::byte_type  rsp_red_byte,
   output rgbe_pkg::byte_type  rsp_green_byte,
   output rgbe_pkg::byte_type  rsp_blue_byte,
   output rgbe_pkg::exp_type   rsp_shared_exponent,
   output rgbe_pkg::float_type rsp_red_linear,
   output rgbe_pkg::float_type rsp_green_linear,
   output rgbe_pkg::float_type rsp_blue_linear
);
   import rgbe_pkg::*;

   logic      vld_ff, rsp_valid_ff;
   op_type    op_ff;
   float_type rv_ff, gv_ff, bv_ff;
   byte_type  rc_ff, gc_ff, bc_ff;
   exp_type   ec_ff;

   byte_type  eb_r, eb_g, eb_b;
   exp_type   ee;
   float_type dl_r, dl_g, dl_b;

   byte_type  rb_in, gb_in, bb_in;
   exp_type   se_in;
   float_type rl_in, gl_in, bl_in;
   byte_type  rb_ff, gb_ff, bb_ff;
   exp_type   se_ff;
   float_type rl_ff, gl_ff, bl_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= start;
         rsp_valid_ff <= vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff <= op_type'(req_operation);
         rv_ff <= req_red_value;
         gv_ff <= req_green_value;
         bv_ff <= req_blue_value;
         rc_ff <= req_red_code;
         gc_ff <= req_green_code;
         bc_ff <= req_blue_code;
         ec_ff <= req_exponent_code;
      end
      rb_ff <= rb_in;
      gb_ff <= gb_in;
      bb_ff <= bb_in;
      se_ff <= se_in;
      rl_ff <= rl_in;
      gl_ff <= gl_in;
      bl_ff <= bl_in;
   end

   rgbe_encoder u_enc (
      .red_value       (rv_ff),
      .green_value     (gv_ff),
      .blue_value      (bv_ff),
      .red_byte        (eb_r),
      .green_byte      (eb_g),
      .blue_byte       (eb_b),
      .shared_exponent (ee)
   );

   rgbe_decoder u_dec (
      .red_code      (rc_ff),
      .green_code    (gc_ff),
      .blue_code     (bc_ff),
      .exponent_code (ec_ff),
      .red_linear    (dl_r),
      .green_linear  (dl_g),
      .blue_linear   (dl_b)
   );

   always_comb begin
      rb_in = 8'd0;
      gb_in = 8'd0;
      bb_in = 8'd0;
      se_in = 8'sd0;
      rl_in = 32'd0;
      gl_in = 32'd0;
      bl_in = 32'd0;
      case (op_ff)
         OP_ENCODE: begin
            rb_in = eb_r;
            gb_in = eb_g;
            bb_in = eb_b;
            se_in = ee;
         end
         OP_DECODE: begin
            rl_in = dl_r;
            gl_in = dl_g;
            bl_in = dl_b;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_red_byte        = rb_ff;
   assign rsp_green_byte      = gb_ff;
   assign rsp_blue_byte       = bb_ff;
   assign rsp_shared_exponent = se_ff;
   assign rsp_red_linear      = rl_ff;
   assign rsp_green_linear    = gl_ff;
   assign rsp_blue_linear     = bl_ff;

endmodule
